/* sv/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types, constants and lookup functions for the rate series airtime
// pipeline.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 8191;

  localparam logic [1:0] MODE_CCK  = 2'd0;
  localparam logic [1:0] MODE_OFDM = 2'd1;
  localparam logic [1:0] MODE_HT   = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [2:0] CRATE_0 = 3'd0;
  localparam logic [2:0] CRATE_2 = 3'd2;
  localparam logic [2:0] CRATE_4 = 3'd4;

  // reciprocal divide: q = (x * mult) >> RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned MULT_W      = 23;
  localparam int unsigned DIV_W       = 17;
  localparam int unsigned PROD_W      = DIV_W + MULT_W;

  // divide by five: ceil(2^19 / 5)
  localparam int unsigned FIVE_SHIFT = 19;
  localparam logic [16:0] FIVE_MULT  = 17'd104858;

  localparam logic [17:0] AIRTIME_MAX = 18'd131071;
  localparam logic [17:0] LSIG_MAX    = 18'd16383;

  typedef struct packed {
    logic               one;   // no odd divisor, shift only
    logic               x2;    // dividend is twice the bit count
    logic [2:0]         sh;    // power-of-two part of the divisor
    logic [9:0]         add;   // rounding and service bits
    logic [MULT_W-1:0]  mult;  // reciprocal of the odd part
  } rsa_div_t;

  typedef struct packed {
    logic       is_cck;
    logic       is_ht;
    logic       shrt;
    logic [8:0] ack;
    logic [8:0] cts;
    logic       ctrl_phy_mode;
    logic [2:0] ctrl_rate_index;
    logic       ctrl_short;
    logic [7:0] try_limit;
    logic       no_ack_policy;
    logic       rts_cts_enable;
    logic       last_series_mark;
  } rsa_side_t;

  typedef struct packed {
    logic        ctrl_phy_mode;
    logic [2:0]  ctrl_rate_index;
    logic        ctrl_short;
    logic [16:0] frame_airtime;
    logic [8:0]  ack_duration;
    logic [16:0] nav_duration;
    logic [13:0] legacy_length;
    logic [7:0]  try_limit;
    logic        no_ack_policy;
    logic        rts_cts_enable;
    logic        last_series_mark;
  } rsa_res_t;

  localparam logic [MULT_W-1:0] M3   = 23'd5592406;
  localparam logic [MULT_W-1:0] M9   = 23'd1864136;
  localparam logic [MULT_W-1:0] M11  = 23'd1525202;
  localparam logic [MULT_W-1:0] M13  = 23'd1290556;
  localparam logic [MULT_W-1:0] M27  = 23'd621379;
  localparam logic [MULT_W-1:0] M39  = 23'd430186;
  localparam logic [MULT_W-1:0] M65  = 23'd258112;
  localparam logic [MULT_W-1:0] M81  = 23'd207127;
  localparam logic [MULT_W-1:0] M117 = 23'd143396;
  localparam logic [MULT_W-1:0] M135 = 23'd124276;
  localparam logic [MULT_W-1:0] M243 = 23'd69043;

  function automatic rsa_div_t mk(logic one, logic x2, logic [2:0] sh, logic [9:0] add,
                                  logic [MULT_W-1:0] mult);
    rsa_div_t d;
    d.one = one; d.x2 = x2; d.sh = sh; d.add = add; d.mult = mult;
    return d;
  endfunction

  // divisor setup; mode already folded (reserved -> OFDM)
  function automatic rsa_div_t div_setup(logic [1:0] mode, logic [2:0] idx, logic wide);
    rsa_div_t d;
    d = mk(1'b1, 1'b0, 3'd0, 10'd0, '0);
    case (mode)
      MODE_CCK: begin
        case (idx[1:0])
          2'd0:    d = mk(1'b1, 1'b0, 3'd0, 10'd0, '0);
          2'd1:    d = mk(1'b1, 1'b0, 3'd1, 10'd1, '0);
          2'd2:    d = mk(1'b0, 1'b1, 3'd0, 10'd10, M11);
          default: d = mk(1'b0, 1'b0, 3'd0, 10'd10, M11);
        endcase
      end
      MODE_HT: begin
        if (!wide) begin
          case (idx)
            3'd0:    d = mk(1'b0, 1'b0, 3'd1, 10'd47, M13);
            3'd1:    d = mk(1'b0, 1'b0, 3'd2, 10'd73, M13);
            3'd2:    d = mk(1'b0, 1'b0, 3'd1, 10'd99, M39);
            3'd3:    d = mk(1'b0, 1'b0, 3'd3, 10'd125, M13);
            3'd4:    d = mk(1'b0, 1'b0, 3'd2, 10'd177, M39);
            3'd5:    d = mk(1'b0, 1'b0, 3'd4, 10'd229, M13);
            3'd6:    d = mk(1'b0, 1'b0, 3'd1, 10'd255, M117);
            default: d = mk(1'b0, 1'b0, 3'd2, 10'd281, M65);
          endcase
        end else begin
          case (idx)
            3'd0:    d = mk(1'b0, 1'b0, 3'd1, 10'd75, M27);
            3'd1:    d = mk(1'b0, 1'b0, 3'd2, 10'd129, M27);
            3'd2:    d = mk(1'b0, 1'b0, 3'd1, 10'd183, M81);
            3'd3:    d = mk(1'b0, 1'b0, 3'd3, 10'd237, M27);
            3'd4:    d = mk(1'b0, 1'b0, 3'd2, 10'd345, M81);
            3'd5:    d = mk(1'b0, 1'b0, 3'd4, 10'd453, M27);
            3'd6:    d = mk(1'b0, 1'b0, 3'd1, 10'd507, M243);
            default: d = mk(1'b0, 1'b0, 3'd2, 10'd561, M135);
          endcase
        end
      end
      default: begin
        case (idx)
          3'd0:    d = mk(1'b0, 1'b0, 3'd3, 10'd45, M3);
          3'd1:    d = mk(1'b0, 1'b0, 3'd2, 10'd57, M9);
          3'd2:    d = mk(1'b0, 1'b0, 3'd4, 10'd69, M3);
          3'd3:    d = mk(1'b0, 1'b0, 3'd3, 10'd93, M9);
          3'd4:    d = mk(1'b0, 1'b0, 3'd5, 10'd117, M3);
          3'd5:    d = mk(1'b0, 1'b0, 3'd4, 10'd165, M9);
          3'd6:    d = mk(1'b0, 1'b0, 3'd6, 10'd213, M3);
          default: d = mk(1'b0, 1'b0, 3'd3, 10'd237, M27);
        endcase
      end
    endcase
    return d;
  endfunction

  // 14-byte control response airtime plus SIFS
  function automatic logic [8:0] resp_time(logic cck, logic [2:0] cidx, logic cshort);
    logic [8:0] t;
    if (cck) begin
      t = cshort ? 9'd218 : 9'd314;
    end else begin
      case (cidx)
        CRATE_0: t = 9'd60;
        CRATE_2: t = 9'd48;
        default: t = 9'd44;
      endcase
    end
    return t;
  endfunction

endpackage

/* sv/rsa_if.sv */
// ----------------------------------------------------------------------------
// rsa_in_if / rsa_out_if
// Valid/ready channels carrying one rate series word and one result word.
// ----------------------------------------------------------------------------
interface rsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phy_mode;
  logic [2:0]  rate_sel;
  logic        short_flag;
  logic        wide_40;
  logic [12:0] frame_length;
  logic [7:0]  tries_allowed;
  logic        unicast;
  logic        use_rts;
  logic        final_series;

  modport source (output valid, phy_mode, rate_sel, short_flag, wide_40, frame_length,
                  tries_allowed, unicast, use_rts, final_series, input ready);
  modport sink (input valid, phy_mode, rate_sel, short_flag, wide_40, frame_length,
                tries_allowed, unicast, use_rts, final_series, output ready);
endinterface

interface rsa_out_if;
  logic        valid;
  logic        ready;
  logic        ctrl_phy_mode;
  logic [2:0]  ctrl_rate_index;
  logic        ctrl_short;
  logic [16:0] frame_airtime;
  logic [8:0]  ack_duration;
  logic [16:0] nav_duration;
  logic [13:0] legacy_length;
  logic [7:0]  try_limit;
  logic        no_ack_policy;
  logic        rts_cts_enable;
  logic        last_series_mark;

  modport source (output valid, ctrl_phy_mode, ctrl_rate_index, ctrl_short, frame_airtime,
                  ack_duration, nav_duration, legacy_length, try_limit, no_ack_policy,
                  rts_cts_enable, last_series_mark, input ready);
  modport sink (input valid, ctrl_phy_mode, ctrl_rate_index, ctrl_short, frame_airtime,
                ack_duration, nav_duration, legacy_length, try_limit, no_ack_policy,
                rts_cts_enable, last_series_mark, output ready);
endinterface

/* sv/rsa_decode.sv */
// ----------------------------------------------------------------------------
// rsa_decode
// Stage 1: mode fold, length clamp, control rate and divisor setup.
// ----------------------------------------------------------------------------
module rsa_decode import rsa_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [1:0]           phy_mode,
  input  logic [2:0]           rate_sel,
  input  logic                 short_flag,
  input  logic                 wide_40,
  input  logic [12:0]          frame_length,
  input  logic [7:0]           tries_allowed,
  input  logic                 unicast,
  input  logic                 use_rts,
  input  logic                 final_series,
  output logic                 valid_r,
  output logic [DIV_W-1:0]     x_r,
  output logic                 one_r,
  output logic [MULT_W-1:0]    mult_r,
  output rsa_side_t            side_r
);

  logic [1:0]  mode;
  logic [12:0] len;
  logic [15:0] bits;
  logic [16:0] y;
  rsa_div_t    d;
  rsa_side_t   side_nxt;
  logic [8:0]  resp;

  always_comb begin
    mode = (phy_mode == MODE_RSVD) ? MODE_OFDM : phy_mode;
    len  = (32'(frame_length) > MAX_FRAME_BYTES) ? 13'(MAX_FRAME_BYTES) : frame_length;
    bits = {len, 3'b000};
    d    = div_setup(mode, rate_sel, wide_40);
    y    = (d.x2 ? {bits, 1'b0} : {1'b0, bits}) + 17'(d.add);

    side_nxt.is_cck = (mode == MODE_CCK);
    side_nxt.is_ht  = (mode == MODE_HT);
    side_nxt.shrt   = short_flag;
    if (mode == MODE_CCK) begin
      side_nxt.ctrl_phy_mode   = 1'b0;
      side_nxt.ctrl_rate_index = CRATE_0;
      side_nxt.ctrl_short      = short_flag;
    end else if (mode == MODE_OFDM) begin
      side_nxt.ctrl_phy_mode   = 1'b1;
      side_nxt.ctrl_rate_index = (rate_sel <= 3'd2) ? CRATE_0 :
                                 (rate_sel <= 3'd4) ? CRATE_2 : CRATE_4;
      side_nxt.ctrl_short      = 1'b0;
    end else begin
      side_nxt.ctrl_phy_mode   = 1'b1;
      side_nxt.ctrl_rate_index = (rate_sel <= 3'd1) ? CRATE_0 :
                                 (rate_sel <= 3'd3) ? CRATE_2 : CRATE_4;
      side_nxt.ctrl_short      = 1'b0;
    end
    resp = resp_time(side_nxt.is_cck, side_nxt.ctrl_rate_index, side_nxt.ctrl_short);
    side_nxt.cts              = resp;
    side_nxt.ack              = unicast ? resp : 9'd0;
    side_nxt.try_limit        = tries_allowed;
    side_nxt.no_ack_policy    = ~unicast;
    side_nxt.rts_cts_enable   = use_rts;
    side_nxt.last_series_mark = final_series;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= y >> d.sh;
      one_r  <= d.one;
      mult_r <= d.mult;
      side_r <= side_nxt;
    end
  end

endmodule

/* sv/rsa_symdiv.sv */
// ----------------------------------------------------------------------------
// rsa_symdiv
// Stage 2: symbol / microsecond count by reciprocal multiply.
// ----------------------------------------------------------------------------
module rsa_symdiv import rsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [DIV_W-1:0]  x_i,
  input  logic              one_i,
  input  logic [MULT_W-1:0] mult_i,
  input  rsa_side_t         side_i,
  output logic              valid_r,
  output logic [DIV_W-1:0]  q_r,
  output rsa_side_t         side_r
);

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(x_i) * PROD_W'(mult_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= one_i ? x_i : DIV_W'(prod >> RECIP_SHIFT);
      side_r <= side_i;
    end
  end

endmodule

/* sv/rsa_gi.sv */
// ----------------------------------------------------------------------------
// rsa_gi
// Stages 3-4: base airtime per PHY and the short GI 3.6 us symbol time.
// ----------------------------------------------------------------------------
module rsa_gi import rsa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  logic [DIV_W-1:0] q_i,
  input  rsa_side_t        side_i,
  output logic             valid_r,
  output logic [17:0]      frame_r,
  output logic [13:0]      q5_r,
  output rsa_side_t        side_r
);

  logic [17:0] frame_nxt;
  logic [15:0] sgi_nxt;
  logic        v3_r;
  logic [17:0] f3_r;
  logic [15:0] sgi_r;
  rsa_side_t   s3_r;
  logic [32:0] prod5;

  always_comb begin
    if (side_i.is_cck) begin
      frame_nxt = 18'(q_i) + (side_i.shrt ? 18'd106 : 18'd202);
    end else if (side_i.is_ht) begin
      frame_nxt = {q_i[15:0], 2'b00} + 18'd52;
    end else begin
      frame_nxt = {q_i[15:0], 2'b00} + 18'd36;
    end
    // HT symbol count stays below 4096
    sgi_nxt = 16'(q_i[11:0]) * 16'd18 + 16'd4;
  end

  assign prod5 = 33'(sgi_r) * 33'(FIVE_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      valid_r <= 1'b0;
    end else if (en) begin
      v3_r    <= valid_i;
      valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_r    <= frame_nxt;
      sgi_r   <= sgi_nxt;
      s3_r    <= side_i;
      frame_r <= f3_r;
      q5_r    <= 14'(prod5 >> FIVE_SHIFT);
      side_r  <= s3_r;
    end
  end

endmodule

/* sv/rsa_finish.sv */
// ----------------------------------------------------------------------------
// rsa_finish
// Stage 5: final airtime, NAV, L-SIG length, saturation; output register.
// ----------------------------------------------------------------------------
module rsa_finish import rsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        valid_i,
  input  logic [17:0] frame_i,
  input  logic [13:0] q5_i,
  input  rsa_side_t   side_i,
  output logic        valid_r,
  output rsa_res_t    res_r
);

  logic [15:0] t_sgi;
  logic [17:0] frame;
  logic [18:0] nav;
  logic [15:0] lq;
  logic [17:0] lsig;
  rsa_res_t    res_nxt;

  always_comb begin
    t_sgi = (16'(q5_i) + 16'd3) & 16'hFFFC;
    frame = (side_i.is_ht && side_i.shrt) ? (18'(t_sgi) + 18'd52) : frame_i;
    nav   = side_i.rts_cts_enable ?
            (19'(frame) + 19'(side_i.ack) + 19'(side_i.cts)) : 19'd0;
    lq    = 16'((frame - 18'd33) >> 2);
    lsig  = side_i.is_ht ? (18'(lq) * 18'd3 - 18'd3) : 18'd0;

    res_nxt.ctrl_phy_mode    = side_i.ctrl_phy_mode;
    res_nxt.ctrl_rate_index  = side_i.ctrl_rate_index;
    res_nxt.ctrl_short       = side_i.ctrl_short;
    res_nxt.frame_airtime    = (frame > AIRTIME_MAX) ? 17'(AIRTIME_MAX) : frame[16:0];
    res_nxt.ack_duration     = side_i.ack;
    res_nxt.nav_duration     = (nav > 19'(AIRTIME_MAX)) ? 17'(AIRTIME_MAX) : nav[16:0];
    res_nxt.legacy_length    = (lsig > LSIG_MAX) ? 14'(LSIG_MAX) : lsig[13:0];
    res_nxt.try_limit        = side_i.try_limit;
    res_nxt.no_ack_policy    = side_i.no_ack_policy;
    res_nxt.rts_cts_enable   = side_i.rts_cts_enable;
    res_nxt.last_series_mark = side_i.last_series_mark;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* sv/wifi_rate_series_airtime_top.sv */
// ----------------------------------------------------------------------------
// wifi_rate_series_airtime_top
// Descriptor timing values for one 802.11 transmit rate series.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one word per rate series (PHY mode, rate, short/GI, 40 MHz,
//            length, tries, unicast/RTS/last flags); valid/ready.
//   out_if : one result word per input word, in order: control response
//            rate, airtime incl. SIFS, ACK time, RTS/CTS NAV, HT L-SIG
//            length and the pass-through flags.
//   Five register stages (decode, symdiv, two in gi, finish); one word per
//   cycle is sustained while the receiver holds ready high. The stage
//   count is set by the two reciprocal multipliers (symbol count, then the
//   short GI divide by five), each followed by a register.
//   All stages advance together; when the receiver holds ready low with a
//   word waiting, the whole pipe freezes and in_if.ready drops, so no word
//   is lost or repeated. Bubbles advance, so an empty output stage never
//   blocks input.
//   Reset (rst_n low, synchronous) clears all valid bits; data registers
//   are not reset.
// ----------------------------------------------------------------------------
module wifi_rate_series_airtime_top import rsa_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rsa_in_if.sink    in_if,
  rsa_out_if.source out_if
);

  logic              en;

  logic              v1;
  logic [DIV_W-1:0]  x1;
  logic              one1;
  logic [MULT_W-1:0] mult1;
  rsa_side_t         side1;

  logic              v2;
  logic [DIV_W-1:0]  q2;
  rsa_side_t         side2;

  logic              v4;
  logic [17:0]       frame4;
  logic [13:0]       q5_4;
  rsa_side_t         side4;

  logic              v5;
  rsa_res_t          res5;

  // global advance: output empty or being taken
  assign en          = !v5 || out_if.ready;
  assign in_if.ready = en;

  rsa_decode #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_if.valid),
    .phy_mode     (in_if.phy_mode),
    .rate_sel     (in_if.rate_sel),
    .short_flag   (in_if.short_flag),
    .wide_40      (in_if.wide_40),
    .frame_length (in_if.frame_length),
    .tries_allowed(in_if.tries_allowed),
    .unicast      (in_if.unicast),
    .use_rts      (in_if.use_rts),
    .final_series (in_if.final_series),
    .valid_r      (v1),
    .x_r          (x1),
    .one_r        (one1),
    .mult_r       (mult1),
    .side_r       (side1)
  );

  rsa_symdiv u_symdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .valid_i(v1),
    .x_i    (x1),
    .one_i  (one1),
    .mult_i (mult1),
    .side_i (side1),
    .valid_r(v2),
    .q_r    (q2),
    .side_r (side2)
  );

  rsa_gi u_gi (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .valid_i(v2),
    .q_i    (q2),
    .side_i (side2),
    .valid_r(v4),
    .frame_r(frame4),
    .q5_r   (q5_4),
    .side_r (side4)
  );

  rsa_finish u_finish (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .valid_i(v4),
    .frame_i(frame4),
    .q5_i   (q5_4),
    .side_i (side4),
    .valid_r(v5),
    .res_r  (res5)
  );

  assign out_if.valid            = v5;
  assign out_if.ctrl_phy_mode    = res5.ctrl_phy_mode;
  assign out_if.ctrl_rate_index  = res5.ctrl_rate_index;
  assign out_if.ctrl_short       = res5.ctrl_short;
  assign out_if.frame_airtime    = res5.frame_airtime;
  assign out_if.ack_duration     = res5.ack_duration;
  assign out_if.nav_duration     = res5.nav_duration;
  assign out_if.legacy_length    = res5.legacy_length;
  assign out_if.try_limit        = res5.try_limit;
  assign out_if.no_ack_policy    = res5.no_ack_policy;
  assign out_if.rts_cts_enable   = res5.rts_cts_enable;
  assign out_if.last_series_mark = res5.last_series_mark;

endmodule
